/* hw/rtl/dll_pkg.sv */
package dll_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_DUMP      = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_REQ,
    S_WALK,
    S_LINK_A,
    S_LINK_B,
    S_LINK_C,
    S_UNL_REQ,
    S_UNL_RD,
    S_UNL_A,
    S_UNL_B,
    S_RESULT,
    S_DUMP_WAIT
  } state_t;

endpackage

/* hw/rtl/dll_alloc.sv */
module dll_alloc #(
  parameter int MAX_NODES = 32,
  parameter int IDX_W = 6
) (
  input  logic [MAX_NODES-1:0] free_map,
  output logic                 any_free,
  output logic [IDX_W-1:0]     free_idx
);

  always_comb begin
    free_idx = IDX_W'(MAX_NODES);
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    any_free = |free_map;
  end

endmodule

/* hw/rtl/doubly_linked_list_engine.sv */
// Linked list of signed values in a pool of MAX_NODES nodes (value, prev and
// next links kept in small memories). One command enters at a time; ready is
// low until its last result transaction is taken. Front and back inserts and
// deletes go straight to the link or unlink states; positional insert, delete,
// search and dump walk the list through a single registered link read, with a
// request state and a walk state for each node (dump also waits on the
// consumer for each element). Values are stored in their low VALUE_WIDTH
// bits.
module doubly_linked_list_engine #(
  parameter int MAX_NODES   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic signed [31:0] in_data_value,
  input  logic [5:0]  in_position,
  input  logic signed [31:0] in_search_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_elem_value,
  output logic [5:0]  out_elem_position,
  output logic        out_last
);

  localparam int IDX_W  = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(MAX_NODES);

  logic [VALUE_WIDTH-1:0] mem_val [MAX_NODES];
  logic [IDX_W-1:0]       mem_nxt [MAX_NODES];
  logic [IDX_W-1:0]       mem_prv [MAX_NODES];

  dll_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, tail_r;
  logic [MAX_NODES-1:0] free_r;
  logic [CNT_W-1:0] count_r;

  logic [2:0]  cmd_r;
  logic [VALUE_WIDTH-1:0] data_r, key_r;
  logic [5:0]  pos_r;
  logic [IDX_W-1:0] cur_r, prv_r, nxt_r, node_r;
  logic [6:0]  step_r;

  logic [VALUE_WIDTH-1:0] rd_val_r;
  logic [IDX_W-1:0] rd_nxt_r, rd_prv_r;
  logic [IDX_W-1:0] rd_addr;

  logic ov_r;
  logic [2:0] st_r;
  logic [31:0] ev_r;
  logic [5:0] ep_r;
  logic lst_r;

  logic any_free;
  logic [IDX_W-1:0] free_idx;

  dll_alloc #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_alloc (
    .free_map(free_r), .any_free(any_free), .free_idx(free_idx)
  );

  logic [31:0] rd_sext;
  assign rd_sext = 32'(signed'(rd_val_r));

  assign in_ready = (state_r == dll_pkg::S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_elem_value = ev_r;
  assign out_elem_position = ep_r;
  assign out_last = lst_r;

  logic in_fire, out_fire;
  assign in_fire = in_valid && in_ready;
  assign out_fire = ov_r && out_ready;

  // registered link read; the walk always reads the current node
  assign rd_addr = cur_r;

  always_ff @(posedge clk) begin
    if (rd_addr < NIL) begin
      rd_val_r <= mem_val[rd_addr[ADDR_W-1:0]];
      rd_nxt_r <= mem_nxt[rd_addr[ADDR_W-1:0]];
      rd_prv_r <= mem_prv[rd_addr[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dll_pkg::S_IDLE:      if (in_fire) state_nxt = dll_pkg::S_DECODE;
      dll_pkg::S_DECODE: begin
        state_nxt = dll_pkg::S_RESULT;
        case (dll_pkg::cmd_t'(cmd_r))
          dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_BACK: begin
            if (any_free) state_nxt = dll_pkg::S_LINK_A;
          end
          dll_pkg::CMD_INS_POS: begin
            if (pos_r != 6'd0 && any_free) begin
              if (pos_r == 6'd1) state_nxt = dll_pkg::S_LINK_A;
              else if (head_r != NIL) state_nxt = dll_pkg::S_WALK_REQ;
            end
          end
          dll_pkg::CMD_DEL_FRONT, dll_pkg::CMD_DEL_BACK: begin
            if (head_r != NIL) state_nxt = dll_pkg::S_UNL_REQ;
          end
          dll_pkg::CMD_DEL_POS: begin
            if (head_r != NIL && pos_r != 6'd0) state_nxt = dll_pkg::S_WALK_REQ;
          end
          default: begin
            if (head_r != NIL) state_nxt = dll_pkg::S_WALK_REQ;
          end
        endcase
      end
      dll_pkg::S_WALK_REQ:  state_nxt = dll_pkg::S_WALK;
      dll_pkg::S_WALK: begin
        case (dll_pkg::cmd_t'(cmd_r))
          dll_pkg::CMD_INS_POS: begin
            if (7'(pos_r) - 7'd1 == step_r) state_nxt = dll_pkg::S_LINK_A;
            else if (rd_nxt_r == NIL) state_nxt = dll_pkg::S_RESULT;
            else state_nxt = dll_pkg::S_WALK_REQ;
          end
          dll_pkg::CMD_DEL_POS: begin
            if (7'(pos_r) == step_r) state_nxt = dll_pkg::S_UNL_A;
            else if (rd_nxt_r == NIL) state_nxt = dll_pkg::S_RESULT;
            else state_nxt = dll_pkg::S_WALK_REQ;
          end
          dll_pkg::CMD_SEARCH: begin
            if (rd_val_r == key_r) state_nxt = dll_pkg::S_RESULT;
            else if (rd_nxt_r == NIL || step_r >= 7'(MAX_NODES))
              state_nxt = dll_pkg::S_RESULT;
            else state_nxt = dll_pkg::S_WALK_REQ;
          end
          default:              state_nxt = dll_pkg::S_DUMP_WAIT;
        endcase
      end
      dll_pkg::S_LINK_A:    state_nxt = dll_pkg::S_LINK_B;
      dll_pkg::S_LINK_B:    state_nxt = dll_pkg::S_LINK_C;
      dll_pkg::S_LINK_C:    state_nxt = dll_pkg::S_RESULT;
      dll_pkg::S_UNL_REQ:   state_nxt = dll_pkg::S_UNL_RD;
      dll_pkg::S_UNL_RD:    state_nxt = dll_pkg::S_UNL_A;
      dll_pkg::S_UNL_A:     state_nxt = dll_pkg::S_UNL_B;
      dll_pkg::S_UNL_B:     state_nxt = dll_pkg::S_RESULT;
      dll_pkg::S_RESULT:    state_nxt = dll_pkg::S_IDLE;
      dll_pkg::S_DUMP_WAIT: begin
        if (out_fire) state_nxt = lst_r ? dll_pkg::S_IDLE : dll_pkg::S_WALK_REQ;
      end
      default:              state_nxt = dll_pkg::S_IDLE;
    endcase
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dll_pkg::S_IDLE;
      head_r  <= NIL;
      tail_r  <= NIL;
      free_r  <= '1;
      count_r <= '0;
      ov_r    <= 1'b0;
      cur_r   <= NIL;
    end else begin
      state_r <= state_nxt;
      if (out_fire) ov_r <= 1'b0;
      case (state_r)
        dll_pkg::S_IDLE: begin
          if (in_fire) begin
            cmd_r  <= in_cmd;
            data_r <= VALUE_WIDTH'(in_data_value);
            key_r  <= VALUE_WIDTH'(in_search_key);
            pos_r  <= in_position;
            st_r   <= dll_pkg::ST_OK;
            ev_r   <= '0;
            ep_r   <= '0;
            lst_r  <= 1'b1;
          end
        end
        dll_pkg::S_DECODE: begin
          step_r <= 7'd1;
          cur_r  <= (cmd_r == dll_pkg::CMD_DEL_BACK) ? tail_r : head_r;
          case (dll_pkg::cmd_t'(cmd_r))
            dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_BACK: begin
              if (!any_free) st_r <= dll_pkg::ST_FULL;
              else prv_r <= (cmd_r == dll_pkg::CMD_INS_FRONT) ? NIL : tail_r;
            end
            dll_pkg::CMD_INS_POS: begin
              if (pos_r == 6'd0) st_r <= dll_pkg::ST_BADPOS;
              else if (!any_free) st_r <= dll_pkg::ST_FULL;
              else if (pos_r == 6'd1) prv_r <= NIL;
              else if (head_r == NIL) st_r <= dll_pkg::ST_BADPOS;
            end
            dll_pkg::CMD_DEL_FRONT, dll_pkg::CMD_DEL_BACK: begin
              if (head_r == NIL) st_r <= dll_pkg::ST_EMPTY;
            end
            dll_pkg::CMD_DEL_POS: begin
              if (head_r == NIL) st_r <= dll_pkg::ST_EMPTY;
              else if (pos_r == 6'd0) st_r <= dll_pkg::ST_BADPOS;
            end
            dll_pkg::CMD_SEARCH: begin
              if (head_r == NIL) st_r <= dll_pkg::ST_NOTFOUND;
            end
            default: begin
              if (head_r == NIL) st_r <= dll_pkg::ST_EMPTY;
            end
          endcase
        end
        dll_pkg::S_WALK: begin
          // rd_* holds node cur_r at 1-based position step_r
          case (dll_pkg::cmd_t'(cmd_r))
            dll_pkg::CMD_INS_POS: begin
              if (7'(pos_r) - 7'd1 == step_r) begin
                prv_r <= cur_r;
              end else if (rd_nxt_r == NIL) begin
                st_r <= dll_pkg::ST_BADPOS;
              end else begin
                cur_r <= rd_nxt_r;
                step_r <= step_r + 7'd1;
              end
            end
            dll_pkg::CMD_DEL_POS: begin
              if (7'(pos_r) != step_r) begin
                if (rd_nxt_r == NIL) st_r <= dll_pkg::ST_BADPOS;
                else begin
                  cur_r <= rd_nxt_r;
                  step_r <= step_r + 7'd1;
                end
              end
            end
            dll_pkg::CMD_SEARCH: begin
              if (rd_val_r == key_r) begin
                ep_r <= step_r[5:0];
              end else if (rd_nxt_r == NIL || step_r >= 7'(MAX_NODES)) begin
                st_r <= dll_pkg::ST_NOTFOUND;
              end else begin
                cur_r <= rd_nxt_r;
                step_r <= step_r + 7'd1;
              end
            end
            default: begin
              ev_r  <= rd_sext;
              ep_r  <= step_r[5:0];
              lst_r <= (rd_nxt_r == NIL) || (step_r >= 7'(MAX_NODES));
              ov_r  <= 1'b1;
            end
          endcase
        end
        dll_pkg::S_DUMP_WAIT: begin
          if (out_fire && !lst_r) begin
            cur_r <= rd_nxt_r;
            step_r <= step_r + 7'd1;
          end
        end
        dll_pkg::S_LINK_A: begin
          node_r <= free_idx;
          free_r[free_idx[ADDR_W-1:0]] <= 1'b0;
          // back insert: prv_r is the tail
          nxt_r <= (prv_r == NIL) ? head_r :
                   (cmd_r == dll_pkg::CMD_INS_POS) ? rd_nxt_r : NIL;
          cur_r <= NIL;
        end
        dll_pkg::S_LINK_B: begin
          if (prv_r == NIL) head_r <= node_r;
          if (nxt_r == NIL) tail_r <= node_r;
          count_r <= count_r + CNT_W'(1);
        end
        dll_pkg::S_UNL_RD: begin
        end
        dll_pkg::S_UNL_A: begin
          prv_r <= rd_prv_r;
          nxt_r <= rd_nxt_r;
          node_r <= cur_r;
          ev_r <= rd_sext;
          cur_r <= NIL;
        end
        dll_pkg::S_UNL_B: begin
          if (prv_r == NIL) head_r <= nxt_r;
          if (nxt_r == NIL) tail_r <= prv_r;
          free_r[node_r[ADDR_W-1:0]] <= 1'b1;
          if (count_r != '0) count_r <= count_r - CNT_W'(1);
        end
        dll_pkg::S_RESULT: begin
          ov_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // link memory writes
  always_ff @(posedge clk) begin
    case (state_r)
      dll_pkg::S_LINK_B: begin
        mem_val[node_r[ADDR_W-1:0]] <= data_r;
        mem_prv[node_r[ADDR_W-1:0]] <= prv_r;
        mem_nxt[node_r[ADDR_W-1:0]] <= nxt_r;
        if (prv_r != NIL) mem_nxt[prv_r[ADDR_W-1:0]] <= node_r;
      end
      dll_pkg::S_LINK_C: begin
        if (nxt_r != NIL) mem_prv[nxt_r[ADDR_W-1:0]] <= node_r;
      end
      dll_pkg::S_UNL_B: begin
        if (prv_r != NIL) mem_nxt[prv_r[ADDR_W-1:0]] <= nxt_r;
        if (nxt_r != NIL) mem_prv[nxt_r[ADDR_W-1:0]] <= prv_r;
      end
      default: begin
      end
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dll_pkg::S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_head_tail_nil: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r == NIL) == (tail_r == NIL))) else $error("head and tail disagree");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dll_pkg::S_IDLE && head_r == NIL) |-> (count_r == '0))
    else $error("count nonzero on empty list");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(st_r)))
    else $error("result dropped");

endmodule
